[hdl/olie_pkg.sv]
// Shared types and constants for the ordered list insert/extract block.
package olie_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int WORD_W       = 32;
	localparam int FUNC_W       = 3;
	localparam int STATUS_W     = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_BACK  = 3'd0,
		FN_POP_BACK   = 3'd1,
		FN_PUSH_FRONT = 3'd2,
		FN_POP_FRONT  = 3'd3,
		FN_INSERT_AT  = 3'd4,
		FN_EXTRACT_AT = 3'd5
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic ext;
	} shift_ctl_t;

endpackage

[hdl/ordered_list_insert_extract.sv]
// Top level of the ordered list: op decode, row of slot cells, output register.
// The result word of each accepted word is held in the output register.
// Throughput: one word per cycle while in_stall is low; the slot cells at and above the index update in parallel.
// in_stall is high only while a result word waits and out_stall holds it.
// Reset clears the entry count and output valid; slot contents stay undefined
// and are read only below the count, so no clearing pass is needed.
module ordered_list_insert_extract import olie_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int POS_W    = $clog2(CAPACITY),
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FUNC_W-1:0]   func,
	input  logic [POS_W-1:0]    position,
	input  logic [WORD_W-1:0]   value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [WORD_W-1:0]   removed_word,
	output logic [CNT_W-1:0]    count
);

	logic [CNT_W-1:0]    cnt_q;
	logic                out_valid_q;
	status_t             status_q;
	logic [WORD_W-1:0]   removed_q;

	logic                acc;
	logic                full;
	logic                empty;
	logic [CNT_W-1:0]    pos_ext;
	logic                ins_d;
	logic                ext_d;
	logic [POS_W-1:0]    idx_d;
	status_t             status_d;
	logic [CNT_W-1:0]    cnt_nxt;
	shift_ctl_t          cell_ctl;
	logic [WORD_W-1:0]   words [CAPACITY];
	logic [CAPACITY-1:0] hits;
	logic [WORD_W-1:0]   rd_word;

	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;
	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign empty    = (cnt_q == '0);
	assign pos_ext  = CNT_W'(position);

	always_comb begin
		ins_d    = 1'b0;
		ext_d    = 1'b0;
		idx_d    = '0;
		status_d = ST_OK;
		case (func_t'(func))
			FN_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_d = 1'b1;
					idx_d = cnt_q[POS_W-1:0];
				end
			end
			FN_POP_BACK: begin
				if (empty) begin
					status_d = ST_BAD;
				end else begin
					ext_d = 1'b1;
					idx_d = POS_W'(cnt_q - CNT_W'(1));
				end
			end
			FN_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_d = 1'b1;
				end
			end
			FN_POP_FRONT: begin
				if (empty) begin
					status_d = ST_BAD;
				end else begin
					ext_d = 1'b1;
				end
			end
			FN_INSERT_AT: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (pos_ext > cnt_q) begin
					status_d = ST_BAD;
				end else begin
					ins_d = 1'b1;
					idx_d = position;
				end
			end
			FN_EXTRACT_AT: begin
				if (pos_ext >= cnt_q) begin
					status_d = ST_BAD;
				end else begin
					ext_d = 1'b1;
					idx_d = position;
				end
			end
			default: begin
				status_d = ST_BAD;
			end
		endcase
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (ins_d) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end else if (ext_d) begin
			cnt_nxt = cnt_q - CNT_W'(1);
		end
	end

	assign cell_ctl.ins = acc && ins_d;
	assign cell_ctl.ext = acc && ext_d;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid_l
			assign left_w = words[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = words[g];
		end else begin : g_mid_r
			assign right_w = words[g+1];
		end
		olie_cell #(
			.INDEX (g),
			.POS_W (POS_W)
		) u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.idx        (idx_d),
			.value      (value),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[g]),
			.hit        (hits[g])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hits[i]) begin
				rd_word = rd_word | words[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q       <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q  <= status_d;
			removed_q <= ext_d ? rd_word : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign removed_word = removed_q;
	assign count        = cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.ins |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the count");

	a_ext_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.ext |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("extract did not shrink the count");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		acc && status_d != ST_OK |=> $stable(cnt_q))
		else $error("refused op changed the count");

	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> removed_word == '0)
		else $error("refused op returned a word");

endmodule

[hdl/olie_cell.sv]
// One list slot: holds a word and shifts it to or from its neighbors.
module olie_cell import olie_pkg::*; #(
	parameter int INDEX = 0,
	parameter int POS_W = 4
) (
	input  logic              clk,
	input  shift_ctl_t        ctl,
	input  logic [POS_W-1:0]  idx,
	input  logic [WORD_W-1:0] value,
	input  logic [WORD_W-1:0] left_word,
	input  logic [WORD_W-1:0] right_word,
	output logic [WORD_W-1:0] word,
	output logic              hit
);

	logic [WORD_W-1:0] entry_q;
	logic              at_idx;
	logic              above_idx;

	assign at_idx    = (idx == POS_W'(INDEX));
	assign above_idx = (idx < POS_W'(INDEX));
	assign hit       = at_idx;
	assign word      = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_idx) begin
				entry_q <= value;
			end else if (above_idx) begin
				entry_q <= left_word;
			end
		end else if (ctl.ext) begin
			if (at_idx || above_idx) begin
				entry_q <= right_word;
			end
		end
	end

endmodule

[verif/ordered_list_insert_extract_tb.sv]
// Self-checking testbench for the ordered list insert/extract block.
module ordered_list_insert_extract_tb import olie_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP         = DEF_CAPACITY;
	localparam int LIMIT_CYCLES = 200000;
	localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   removed;
		logic [4:0]          count;
	} list_result_t;

	typedef struct packed {
		logic [FUNC_W-1:0] f;
		logic [3:0]        p;
		logic [WORD_W-1:0] w;
		logic              typed;
		list_result_t      res;
	} stim_row_t;

	typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED} episode_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [FUNC_W-1:0]   func         = '0;
	logic [3:0]          position     = '0;
	logic [WORD_W-1:0]   value        = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   removed_word;
	logic [4:0]          count;

	// predictor state
	logic [WORD_W-1:0] list_words [CAP];
	int                list_len = 0;

	list_result_t pending_results[$];
	list_result_t next_expected;
	stim_row_t    directed_rows[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int words_sent = 0;
	int words_checked = 0;
	int cycle_count = 0;
	int peak_len = 0;
	int status_seen [4] = '{0, 0, 0, 0};

	ordered_list_insert_extract uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.removed_word(removed_word),
		.count(count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t ns: timeout with %0d words outstanding", $time,
				pending_results.size());
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// outputs are stable at the falling edge; a word accepted at the next rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			words_checked++;
			status_seen[status]++;
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result word status %0d removed %h count %0d",
					$time, status, removed_word, count);
				fail_count++;
			end else begin
				next_expected = pending_results[0];
				pending_results.delete(0);
				if (status !== next_expected.status) begin
					$display("%0t ns: status expected %0d got %0d", $time,
						next_expected.status, status);
					fail_count++;
				end
				if (removed_word !== next_expected.removed) begin
					$display("%0t ns: removed_word expected %h got %h", $time,
						next_expected.removed, removed_word);
					fail_count++;
				end
				if (count !== next_expected.count) begin
					$display("%0t ns: count expected %0d got %0d", $time,
						next_expected.count, count);
					fail_count++;
				end
			end
		end
	end

	function automatic void open_at(int idx, logic [WORD_W-1:0] w);
		for (int i = list_len; i > idx; i--)
			list_words[i] = list_words[i-1];
		list_words[idx] = w;
		list_len++;
		if (list_len > peak_len)
			peak_len = list_len;
	endfunction

	function automatic logic [WORD_W-1:0] close_at(int idx);
		logic [WORD_W-1:0] w;
		w = list_words[idx];
		for (int i = idx; i + 1 < list_len; i++)
			list_words[i] = list_words[i+1];
		list_len--;
		return w;
	endfunction

	function automatic list_result_t list_op_result(logic [FUNC_W-1:0] f, logic [3:0] p,
			logic [WORD_W-1:0] w);
		list_result_t r;
		bit full;
		r.status = ST_OK;
		r.removed = '0;
		full = (list_len >= CAP);
		case (f)
			FN_PUSH_BACK: begin
				if (full) r.status = ST_FULL;
				else open_at(list_len, w);
			end
			FN_POP_BACK: begin
				if (list_len == 0) r.status = ST_BAD;
				else r.removed = close_at(list_len - 1);
			end
			FN_PUSH_FRONT: begin
				if (full) r.status = ST_FULL;
				else open_at(0, w);
			end
			FN_POP_FRONT: begin
				if (list_len == 0) r.status = ST_BAD;
				else r.removed = close_at(0);
			end
			FN_INSERT_AT: begin
				if (full) r.status = ST_FULL;
				else if (int'(p) > list_len) r.status = ST_BAD;
				else open_at(int'(p), w);
			end
			FN_EXTRACT_AT: begin
				if (int'(p) >= list_len) r.status = ST_BAD;
				else r.removed = close_at(int'(p));
			end
			default: r.status = ST_BAD;
		endcase
		r.count = 5'(list_len);
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(logic [FUNC_W-1:0] f, logic [3:0] p, logic [WORD_W-1:0] w,
			logic typed, list_result_t typed_res);
		bit fire;
		list_result_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		position <= p;
		value <= w;
		fire = 1'b0;
		while (!fire) begin
			@(negedge clk);
			fire = !in_stall;
			@(posedge clk);
		end
		pred = list_op_result(f, p, w);
		pending_results = {pending_results, (typed ? typed_res : pred)};
		words_sent++;
	endtask

	task automatic send_random(logic [FUNC_W-1:0] f, logic [3:0] p);
		send_word(f, p, pick_word(), 1'b0, '0);
	endtask

	task automatic wait_for_results();
		if (pending_results.size() != 0) begin
			in_valid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
		end
	endtask

	task automatic add_row(logic [FUNC_W-1:0] f, logic [3:0] p, logic [WORD_W-1:0] w,
			logic typed, logic [STATUS_W-1:0] st, logic [WORD_W-1:0] rm, logic [4:0] ct);
		stim_row_t row;
		row.f = f;
		row.p = p;
		row.w = w;
		row.typed = typed;
		row.res.status = st;
		row.res.removed = rm;
		row.res.count = ct;
		directed_rows = {directed_rows, row};
	endtask

	task automatic run_random(int n_words);
		int done;
		int reps;
		episode_t ep;
		logic [FUNC_W-1:0] f;
		done = 0;
		while (done < n_words) begin
			ep = (done == 0) ? EP_FILL : episode_t'($urandom_range(2));
			case (ep)
				EP_FILL: begin
					while (list_len < CAP) begin
						case ($urandom_range(2))
							0: send_random(FN_PUSH_BACK, 4'($urandom));
							1: send_random(FN_PUSH_FRONT, 4'($urandom));
							default: send_random(FN_INSERT_AT, 4'($urandom_range(list_len)));
						endcase
						done++;
					end
					reps = $urandom_range(3, 1);
					repeat (reps) begin
						case ($urandom_range(2))
							0: f = FN_PUSH_BACK;
							1: f = FN_PUSH_FRONT;
							default: f = FN_INSERT_AT;
						endcase
						send_random(f, 4'($urandom));
						done++;
					end
					if ($urandom_range(7) == 0)
						wait_for_results();
				end
				EP_DRAIN: begin
					reps = $urandom_range(list_len, 1);
					repeat (reps) begin
						if (list_len > 0) begin
							case ($urandom_range(2))
								0: send_random(FN_POP_BACK, 4'($urandom));
								1: send_random(FN_POP_FRONT, 4'($urandom));
								default:
									send_random(FN_EXTRACT_AT,
										4'($urandom_range(list_len - 1)));
							endcase
							done++;
						end
					end
					if (list_len == 0) begin
						case ($urandom_range(2))
							0: send_random(FN_POP_BACK, 4'($urandom));
							1: send_random(FN_POP_FRONT, 4'($urandom));
							default: send_random(FN_EXTRACT_AT, 4'($urandom));
						endcase
						done++;
					end
				end
				default: begin
					reps = $urandom_range(20, 5);
					repeat (reps) begin
						f = 3'($urandom_range(7));
						if ($urandom_range(1) == 0 && list_len > 0)
							send_random(f, 4'($urandom_range(list_len - 1)));
						else
							send_random(f, 4'($urandom));
						done++;
					end
				end
			endcase
		end
	endtask

	initial begin
		// empty list refusals, spare codes, extremes, then shifts in the middle
		add_row(FN_POP_BACK,   4'd0,  32'h0000_0000, 1'b1, ST_BAD, '0, 5'd0);
		add_row(FN_POP_FRONT,  4'd0,  32'h0000_0000, 1'b1, ST_BAD, '0, 5'd0);
		add_row(FN_EXTRACT_AT, 4'd0,  32'h0000_0000, 1'b1, ST_BAD, '0, 5'd0);
		add_row(FN_SPARE_6,    4'd0,  32'h1234_5678, 1'b1, ST_BAD, '0, 5'd0);
		add_row(FN_SPARE_7,    4'd15, 32'hFFFF_FFFF, 1'b1, ST_BAD, '0, 5'd0);
		add_row(FN_INSERT_AT,  4'd1,  32'h0000_0001, 1'b1, ST_BAD, '0, 5'd0);
		add_row(FN_PUSH_BACK,  4'd15, 32'h7FFF_FFFF, 1'b1, ST_OK,  '0, 5'd1);
		add_row(FN_PUSH_FRONT, 4'd0,  32'h8000_0000, 1'b1, ST_OK,  '0, 5'd2);
		add_row(FN_INSERT_AT,  4'd2,  32'hFFFF_FFFF, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_INSERT_AT,  4'd0,  32'h0000_0000, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_INSERT_AT,  4'd2,  32'h0000_0001, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_EXTRACT_AT, 4'd15, 32'h0000_0000, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_INSERT_AT,  4'd15, 32'h0000_0002, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_EXTRACT_AT, 4'd2,  32'h0000_0000, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_EXTRACT_AT, 4'd0,  32'hFFFF_FFFF, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_SPARE_6,    4'd10, 32'h5555_5555, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_PUSH_BACK,  4'd5,  32'h5555_5555, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_PUSH_FRONT, 4'd10, 32'hAAAA_AAAA, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_EXTRACT_AT, 4'd1,  32'h0000_0000, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_POP_BACK,   4'd0,  32'h0000_0000, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_POP_FRONT,  4'd0,  32'h0000_0000, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_POP_BACK,   4'd0,  32'h0000_0000, 1'b0, ST_OK,  '0, 5'd0);
		add_row(FN_POP_FRONT,  4'd0,  32'h0000_0000, 1'b0, ST_OK,  '0, 5'd0);

		send_idle_pct = 34;
		recv_stall_pct = 78;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].f, directed_rows[i].p, directed_rows[i].w,
				directed_rows[i].typed, directed_rows[i].res);
		run_random(200);
		wait_for_results();

		send_idle_pct = 78;
		recv_stall_pct = 34;
		run_random(215);
		wait_for_results();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(215);
		wait_for_results();
		repeat (4) @(posedge clk);

		$display("sent %0d words, checked %0d results, peak list length %0d of %0d",
			words_sent, words_checked, peak_len, CAP);
		$display("status counts: ok %0d, full %0d, refused %0d; %0d mismatches",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD], fail_count);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/olie_pkg.sv
hdl/olie_cell.sv
hdl/ordered_list_insert_extract.sv
verif/ordered_list_insert_extract_tb.sv
